// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk_i and gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define VCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define VCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/vcs_pkg.sv -----
// ----------------------------------------------------------------------------
// vcs_pkg
// shared types and codes of the voxel column store
// ----------------------------------------------------------------------------
package vcs_pkg;

  typedef enum logic [1:0] {
    MODE_READ     = 2'd0,
    MODE_WRITE    = 2'd1,
    MODE_EDGE     = 2'd2,
    MODE_REMESHED = 2'd3
  } mode_e;

  // register index taken from paddr[2]
  localparam logic [0:0] REG_AIR_CODE = 1'b0;

  // neighbor mask bit positions
  localparam int unsigned NB_W  = 0;
  localparam int unsigned NB_E  = 1;
  localparam int unsigned NB_N  = 2;
  localparam int unsigned NB_S  = 3;
  localparam int unsigned NB_NW = 4;
  localparam int unsigned NB_SW = 5;
  localparam int unsigned NB_NE = 6;
  localparam int unsigned NB_SE = 7;

  typedef struct packed {
    mode_e      mode;
    logic [3:0] col_x;
    logic [3:0] col_z;
    logic [7:0] level_y;
    logic [7:0] block_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_code;
    logic       changed;
    logic [7:0] column_height;
    logic [7:0] neighbor_mask;
    logic       dirty_flag;
    logic       level_uniform;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic eval;
    logic scan_rd;
    logic scan_dec;
    logic scan_fin;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_scan;
    logic top_zero;
    logic cell_air;
  } sts_t;

endpackage

// ----- rtl/vcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// vcs_ctrl
// sequencer: clearing pass, lookup, column scan and result transfer
// ----------------------------------------------------------------------------
module vcs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  vcs_pkg::sts_t sts_i,
  output vcs_pkg::cmd_t cmd_o
);
  import vcs_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_LOOKUP   = 6'b000100,
    ST_SCAN_RD  = 6'b001000,
    ST_SCAN_CHK = 6'b010000,
    ST_RESP     = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.need_scan ? ST_SCAN_RD : ST_RESP;
      end
      ST_SCAN_RD: begin
        if (sts_i.top_zero) begin
          cmd_o.scan_fin = 1'b1;
          state_d        = ST_RESP;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (sts_i.cell_air) begin
          cmd_o.scan_dec = 1'b1;
          state_d        = ST_SCAN_RD;
        end else begin
          cmd_o.scan_fin = 1'b1;
          state_d        = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/vcs_datapath.sv -----
// ----------------------------------------------------------------------------
// vcs_datapath
// cell and height memories, level flags, dirty flag and result registers
// ----------------------------------------------------------------------------
module vcs_datapath #(
  parameter int unsigned CHUNK_WIDTH  = 16,
  parameter int unsigned WORLD_HEIGHT = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vcs_pkg::cmd_t      cmd_i,
  output vcs_pkg::sts_t      sts_o,
  input  vcs_pkg::in_item_t  in_data_i,
  input  logic [7:0]         air_code_i,
  output vcs_pkg::out_item_t out_data_o
);
  import vcs_pkg::*;

  localparam int unsigned NCOL      = CHUNK_WIDTH * CHUNK_WIDTH;
  localparam int unsigned NCELL     = NCOL * WORLD_HEIGHT;
  localparam int unsigned COL_W     = $clog2(NCOL);
  localparam int unsigned CELL_W    = $clog2(NCELL);
  localparam int unsigned LVL_W     = $clog2(WORLD_HEIGHT);
  localparam int unsigned XZ_MASK   = CHUNK_WIDTH - 1;
  localparam int unsigned TOP_LEVEL = WORLD_HEIGHT - 1;

  function automatic logic [COL_W-1:0] col_of(logic [3:0] cx, logic [3:0] cz);
    int unsigned xm;
    int unsigned zm;
    xm = 32'(cx) & XZ_MASK;
    zm = 32'(cz) & XZ_MASK;
    return COL_W'(xm * CHUNK_WIDTH + zm);
  endfunction

  function automatic logic [CELL_W-1:0] cell_of(logic [COL_W-1:0] col, logic [7:0] yy);
    return CELL_W'(32'(col) * WORLD_HEIGHT + 32'(yy));
  endfunction

  // memories
  logic [7:0] cell_mem [NCELL];
  logic [7:0] hgt_mem  [NCOL];
  logic       lvl_mem  [WORLD_HEIGHT];

  logic              cell_we, cell_re;
  logic [CELL_W-1:0] cell_wa, cell_ra;
  logic [7:0]        cell_wd, cell_rd_q;
  logic              hgt_we;
  logic [COL_W-1:0]  hgt_wa;
  logic [7:0]        hgt_wd, hgt_rd_q;
  logic              lvl_we, lvl_wd, lvl_rd_q;
  logic [LVL_W-1:0]  lvl_wa;

  // control and item state
  logic [CELL_W-1:0]     clr_q;
  logic                  dirty_q, dirty_d;
  in_item_t              it_q;
  logic [COL_W-1:0]      col_q;
  logic [CELL_W-1:0]     addr_q;
  logic [7:0]            top_q;
  out_item_t             res_q, out_q;

  logic              below_top, in_world, wr, is_air, lower, raise, clr_hgt, clr_lvl;
  logic [LVL_W-1:0]  y_idx;
  logic [8:0]        y1;
  logic [COL_W-1:0]  load_col;
  logic [7:0]        mask;
  logic              nb_w, nb_e, nb_n, nb_s;
  int unsigned       xm, zm;

  assign load_col  = col_of(in_data_i.col_x, in_data_i.col_z);
  assign below_top = 32'(it_q.level_y) < TOP_LEVEL;
  assign in_world  = 32'(it_q.level_y) < WORLD_HEIGHT;
  assign y_idx     = it_q.level_y[LVL_W-1:0];
  assign y1        = {1'b0, it_q.level_y} + 9'd1;
  assign is_air    = it_q.block_code == air_code_i;
  assign wr        = (it_q.mode == MODE_WRITE) && below_top && (cell_rd_q != it_q.block_code);
  assign lower     = wr && is_air && ({1'b0, hgt_rd_q} == y1);
  assign raise     = wr && !is_air && ({1'b0, hgt_rd_q} < y1);
  assign clr_hgt   = 32'(clr_q) < NCOL;
  assign clr_lvl   = 32'(clr_q) < WORLD_HEIGHT;

  always_comb begin
    xm   = 32'(it_q.col_x) & XZ_MASK;
    zm   = 32'(it_q.col_z) & XZ_MASK;
    nb_w = xm == 0;
    nb_e = xm == XZ_MASK;
    nb_n = zm == 0;
    nb_s = zm == XZ_MASK;
    mask = '0;
    mask[NB_W]  = nb_w;
    mask[NB_E]  = nb_e;
    mask[NB_N]  = nb_n;
    mask[NB_S]  = nb_s;
    mask[NB_NW] = nb_w && nb_n;
    mask[NB_SW] = nb_w && nb_s;
    mask[NB_NE] = nb_e && nb_n;
    mask[NB_SE] = nb_e && nb_s;
  end

  always_comb begin
    dirty_d = dirty_q;
    if (wr) begin
      dirty_d = 1'b1;
    end else if (it_q.mode == MODE_EDGE) begin
      dirty_d = 1'b1;
    end else if (it_q.mode == MODE_REMESHED) begin
      dirty_d = 1'b0;
    end
  end

  // memory port muxing
  always_comb begin
    cell_we = cmd_i.clear || (cmd_i.eval && wr);
    cell_wa = cmd_i.clear ? clr_q : addr_q;
    cell_wd = cmd_i.clear ? 8'd0 : it_q.block_code;
    cell_re = cmd_i.load || cmd_i.scan_rd;
    cell_ra = cmd_i.load ? cell_of(load_col, in_data_i.level_y)
                         : CELL_W'(32'(col_q) * WORLD_HEIGHT + 32'(top_q) - 32'd1);
    hgt_we  = (cmd_i.clear && clr_hgt) || (cmd_i.eval && raise) || cmd_i.scan_fin;
    hgt_wa  = cmd_i.clear ? clr_q[COL_W-1:0] : col_q;
    if (cmd_i.clear) begin
      hgt_wd = 8'd0;
    end else if (cmd_i.scan_fin) begin
      hgt_wd = top_q;
    end else begin
      hgt_wd = y1[7:0];
    end
    lvl_we  = (cmd_i.clear && clr_lvl) || (cmd_i.eval && wr);
    lvl_wa  = cmd_i.clear ? clr_q[LVL_W-1:0] : y_idx;
    lvl_wd  = cmd_i.clear;
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_wa] <= cell_wd;
    end
    if (cell_re) begin
      cell_rd_q <= cell_mem[cell_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hgt_we) begin
      hgt_mem[hgt_wa] <= hgt_wd;
    end
    if (cmd_i.load) begin
      hgt_rd_q <= hgt_mem[load_col];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lvl_we) begin
      lvl_mem[lvl_wa] <= lvl_wd;
    end
    if (cmd_i.load) begin
      lvl_rd_q <= lvl_mem[in_data_i.level_y[LVL_W-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      dirty_q <= 1'b1;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + CELL_W'(1);
      end
      if (cmd_i.eval) begin
        dirty_q <= dirty_d;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q   <= in_data_i;
      col_q  <= load_col;
      addr_q <= cell_of(load_col, in_data_i.level_y);
    end
    if (cmd_i.eval) begin
      top_q               <= it_q.level_y;
      res_q.read_code     <= below_top ? (wr ? it_q.block_code : cell_rd_q) : air_code_i;
      res_q.changed       <= wr;
      res_q.column_height <= raise ? y1[7:0] : hgt_rd_q;
      res_q.neighbor_mask <= wr ? mask : 8'd0;
      res_q.dirty_flag    <= dirty_d;
      res_q.level_uniform <= in_world ? (!wr && lvl_rd_q) : 1'b1;
    end
    if (cmd_i.scan_dec) begin
      top_q <= top_q - 8'd1;
    end
    if (cmd_i.scan_fin) begin
      res_q.column_height <= top_q;
    end
    if (cmd_i.push) begin
      out_q <= res_q;
    end
  end

  assign sts_o.clear_last = clr_q == CELL_W'(NCELL - 1);
  assign sts_o.need_scan  = lower;
  assign sts_o.top_zero   = top_q == 8'd0;
  assign sts_o.cell_air   = cell_rd_q == air_code_i;
  assign out_data_o       = out_q;

endmodule

// ----- rtl/voxel_column_store_with_heightmap_unit.sv -----
// ----------------------------------------------------------------------------
// voxel_column_store_with_heightmap_unit
// chunk block store with per-column height map, level flags and dirty flag
// ----------------------------------------------------------------------------
// input channel in_valid_i/in_ready_o carries one operation (read, write,
// neighbor edge changed, remeshed); output channel out_valid_o/out_ready_i
// returns one result per operation. air_code is written over the APB port.
// after reset the block runs a clearing pass over the cell memory of
// CHUNK_WIDTH*CHUNK_WIDTH*WORLD_HEIGHT cells (65536 at the defaults), one
// cell per cycle, with in_ready_o low; configuration transfers are taken.
// one operation at a time: accept, lookup, result; the lookup result is
// registered, then moved into the output register; the next input is taken
// only after that move. a write of air that removes the column top scans
// down the column through the single memory read port, with one read step
// and one check step per level. results wait in an output register, so a
// stalled receiver holds the block in its result stage only once that
// register is full; the next input is still taken while a result waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module voxel_column_store_with_heightmap_unit #(
  parameter int unsigned CHUNK_WIDTH  = 16,
  parameter int unsigned WORLD_HEIGHT = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vcs_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vcs_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import vcs_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [7:0] air_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      air_code_q <= 8'd0;
    end else if (psel && penable && pwrite && (paddr[2:2] == REG_AIR_CODE)) begin
      air_code_q <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == REG_AIR_CODE) ? {24'd0, air_code_q} : 32'd0;

  vcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vcs_datapath #(
    .CHUNK_WIDTH  (CHUNK_WIDTH),
    .WORLD_HEIGHT (WORLD_HEIGHT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .air_code_i (air_code_q),
    .out_data_o (out_data_o)
  );

  `VCS_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o, "input taken twice")
  `VCS_ASSERT(a_no_input_in_clear, !(cmd.clear && in_ready_o), "input ready during clearing")
  `VCS_ASSERT(a_cmd_onehot0, $onehot0(cmd), "conflicting datapath commands")
  `VCS_ASSERT_NEXT(a_push_shows_result, cmd.push, out_valid_o, "result loaded but not valid")

endmodule

// ----- dv/tb_voxel_column_store_with_heightmap_unit.sv -----
// ----------------------------------------------------------------------------
// tb_voxel_column_store_with_heightmap_unit
// self-checking bench for the voxel column store with height map
// ----------------------------------------------------------------------------
// drives read, write, edge and remeshed operations over the valid/ready
// input channel and checks every result transfer against a chunk model kept
// in the bench: cells, column heights, level flags and the dirty flag.
// a directed set covers chunk corners, the top level, unchanged writes and
// column scans. random traffic then concentrates on four hot columns and on
// low levels, and knocks out column tops with air writes so that scans run,
// under several air codes and with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_voxel_column_store_with_heightmap_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import vcs_pkg::*;

  localparam int unsigned QUIET_LIMIT = 200000;
  localparam int unsigned RANDOM_OPS  = 445;
  localparam int unsigned HOLD_CYCLES = 300;

  class chunk_board;
    bit [7:0]  cells [65536];
    bit [7:0]  heights [256];
    bit        level_flat [256];
    bit        dirty;
    bit [7:0]  air;
    out_item_t expected_q [$];
    int unsigned errors;
    int unsigned ops;
    int unsigned results;
    int unsigned changes;
    int unsigned scans;

    function new();
      foreach (cells[i]) cells[i] = '0;
      foreach (heights[i]) heights[i] = '0;
      foreach (level_flat[i]) level_flat[i] = 1'b1;
      dirty = 1'b1;
      air = '0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void compare(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void note_input(in_item_t op);
      out_item_t  res;
      bit [15:0]  idx;
      bit [7:0]   col;
      bit         below_top;
      int unsigned h;
      int unsigned top;
      idx = {op.col_x, op.col_z, op.level_y};
      col = {op.col_x, op.col_z};
      below_top = op.level_y != 8'd255;
      res = '0;
      ops++;
      if (op.mode == MODE_WRITE && below_top && cells[idx] != op.block_code) begin
        cells[idx] = op.block_code;
        dirty = 1'b1;
        h = heights[col];
        if (op.block_code == air && op.level_y < h && h <= op.level_y + 1) begin
          top = op.level_y;
          while (top > 0 && cells[{op.col_x, op.col_z, 8'(top - 1)}] == air) top--;
          heights[col] = 8'(top);
          scans++;
        end else if (op.block_code != air && h < op.level_y + 1) begin
          heights[col] = op.level_y + 8'd1;
        end
        level_flat[op.level_y] = 1'b0;
        res.changed = 1'b1;
        changes++;
        res.neighbor_mask[NB_W]  = op.col_x == 4'd0;
        res.neighbor_mask[NB_E]  = op.col_x == 4'd15;
        res.neighbor_mask[NB_N]  = op.col_z == 4'd0;
        res.neighbor_mask[NB_S]  = op.col_z == 4'd15;
        res.neighbor_mask[NB_NW] = op.col_x == 4'd0 && op.col_z == 4'd0;
        res.neighbor_mask[NB_SW] = op.col_x == 4'd0 && op.col_z == 4'd15;
        res.neighbor_mask[NB_NE] = op.col_x == 4'd15 && op.col_z == 4'd0;
        res.neighbor_mask[NB_SE] = op.col_x == 4'd15 && op.col_z == 4'd15;
      end else if (op.mode == MODE_EDGE) begin
        dirty = 1'b1;
      end else if (op.mode == MODE_REMESHED) begin
        dirty = 1'b0;
      end
      res.read_code     = below_top ? cells[idx] : air;
      res.column_height = heights[col];
      res.dirty_flag    = dirty;
      res.level_uniform = level_flat[op.level_y];
      expected_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      results++;
      if (expected_q.size() == 0) begin
        $error("result transfer with no operation outstanding");
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare("read_code", exp_r.read_code, got.read_code);
      compare("changed", exp_r.changed, got.changed);
      compare("column_height", exp_r.column_height, got.column_height);
      compare("neighbor_mask", exp_r.neighbor_mask, got.neighbor_mask);
      compare("dirty_flag", exp_r.dirty_flag, got.dirty_flag);
      compare("level_uniform", exp_r.level_uniform, got.level_uniform);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  chunk_board  board = new();
  int unsigned src_idle = 0;
  int unsigned dst_idle = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;
  logic [3:0]  hot_x [4];
  logic [3:0]  hot_z [4];
  bit [7:0]    air_seen [$];

  voxel_column_store_with_heightmap_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // result side: check transfers, random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_data_o);
    if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= $urandom_range(99) >= dst_idle;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_voxel_column_store_with_heightmap_unit: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic in_item_t mk_op(mode_e mode, logic [3:0] x, logic [3:0] z,
                                     logic [7:0] y, logic [7:0] code);
    in_item_t op;
    op.mode       = mode;
    op.col_x      = x;
    op.col_z      = z;
    op.level_y    = y;
    op.block_code = code;
    return op;
  endfunction

  function automatic in_item_t random_op();
    in_item_t    op;
    int unsigned pick;
    int unsigned sel;
    sel = $urandom_range(3);
    if ($urandom_range(99) < 75) begin
      op.col_x = hot_x[sel];
      op.col_z = hot_z[sel];
    end else begin
      op.col_x = 4'($urandom_range(15));
      op.col_z = 4'($urandom_range(15));
    end
    pick = $urandom_range(99);
    if (pick < 70) op.level_y = 8'($urandom_range(15));
    else if (pick < 90) op.level_y = 8'($urandom_range(63));
    else if (pick < 98) op.level_y = 8'($urandom_range(254));
    else op.level_y = 8'd255;
    pick = $urandom_range(99);
    if (pick < 45) op.block_code = board.air;
    else if (pick < 80) op.block_code = board.air + 8'($urandom_range(1, 3));
    else op.block_code = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 25) begin
      op.mode = MODE_READ;
    end else if (pick < 85) begin
      op.mode = MODE_WRITE;
      // knock out the column top now and then so the scan runs
      if ($urandom_range(99) < 25 && board.heights[{op.col_x, op.col_z}] != 0) begin
        op.level_y    = board.heights[{op.col_x, op.col_z}] - 8'd1;
        op.block_code = board.air;
      end
    end else if (pick < 92) begin
      op.mode = MODE_EDGE;
    end else begin
      op.mode = MODE_REMESHED;
    end
    return op;
  endfunction

  task automatic push_op(in_item_t op);
    while ($urandom_range(99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= op;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_input(op);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_air(logic [7:0] code);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_AIR_CODE, 2'b00};
    pwdata  <= {24'd0, code};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    board.air = code;
    air_seen.push_back(code);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    board.compare("air_code", code, prdata[7:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_directed();
    push_op(mk_op(MODE_READ, 4'd0, 4'd0, 8'd0, 8'd0));
    push_op(mk_op(MODE_REMESHED, 4'd15, 4'd15, 8'd255, 8'd255));
    push_op(mk_op(MODE_READ, 4'd15, 4'd15, 8'd255, 8'd0));
    push_op(mk_op(MODE_WRITE, 4'd0, 4'd0, 8'd0, 8'd255));
    push_op(mk_op(MODE_WRITE, 4'd15, 4'd15, 8'd10, 8'h80));
    push_op(mk_op(MODE_WRITE, 4'd0, 4'd15, 8'd3, 8'd1));
    push_op(mk_op(MODE_WRITE, 4'd15, 4'd0, 8'd254, 8'h7f));
    push_op(mk_op(MODE_WRITE, 4'd15, 4'd0, 8'd254, 8'h7f));
    push_op(mk_op(MODE_WRITE, 4'd15, 4'd0, 8'd255, 8'd5));
    push_op(mk_op(MODE_WRITE, 4'd7, 4'd8, 8'd254, 8'haa));
    push_op(mk_op(MODE_WRITE, 4'd7, 4'd8, 8'd100, 8'h55));
    push_op(mk_op(MODE_WRITE, 4'd7, 4'd8, 8'd254, 8'd0));
    push_op(mk_op(MODE_WRITE, 4'd15, 4'd0, 8'd254, 8'd0));
    push_op(mk_op(MODE_EDGE, 4'd3, 4'd4, 8'd20, 8'd9));
    push_op(mk_op(MODE_REMESHED, 4'd3, 4'd4, 8'd20, 8'd9));
    push_op(mk_op(MODE_WRITE, 4'd15, 4'd15, 8'd2, 8'd3));
    push_op(mk_op(MODE_WRITE, 4'd15, 4'd15, 8'd10, 8'd0));
    push_op(mk_op(MODE_WRITE, 4'd15, 4'd15, 8'd2, 8'd0));
    push_op(mk_op(MODE_WRITE, 4'd5, 4'd5, 8'd5, 8'd0));
    push_op(mk_op(MODE_READ, 4'd0, 4'd0, 8'd0, 8'd0));
    push_op(mk_op(MODE_WRITE, 4'd8, 4'd9, 8'd0, 8'd0));
    push_op(mk_op(MODE_WRITE, 4'd8, 4'd9, 8'd0, 8'd1));
    push_op(mk_op(MODE_WRITE, 4'd8, 4'd9, 8'd0, 8'd0));
  endtask

  initial begin
    logic [7:0] air_next;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle = 9;
    dst_idle = 84;
    run_directed();
    drain();
    for (int blk = 0; blk < 4; blk++) begin
      case (blk)
        0: air_next = 8'd255;
        1: air_next = 8'd0;
        2: air_next = 8'($urandom_range(1, 254));
        default: air_next = 8'd0;
      endcase
      src_idle = (blk == 0) ? 9 : (blk == 1) ? 84 : 0;
      dst_idle = (blk == 0) ? 84 : (blk == 1) ? 9 : 0;
      set_air(air_next);
      hot_x[0] = 4'd0;
      hot_z[0] = 4'd0;
      hot_x[1] = 4'd15;
      hot_z[1] = 4'($urandom_range(15));
      hot_x[2] = 4'($urandom_range(15));
      hot_z[2] = 4'd15;
      hot_x[3] = 4'($urandom_range(15));
      hot_z[3] = 4'($urandom_range(15));
      if (blk == 0) hold_req <= hold_req + 1;
      for (int i = 0; i < RANDOM_OPS; i++) push_op(random_op());
      drain();
    end
    repeat (20) @(posedge clk_i);
    $display("covered %0d operations and %0d results: %0d cell changes, %0d column scans",
             board.ops, board.results, board.changes, board.scans);
    $display("air codes used: %p, with one long result stall", air_seen);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_voxel_column_store_with_heightmap_unit: clean");
    end else begin
      $display("tb_voxel_column_store_with_heightmap_unit: errors");
    end
    $finish;
  end

endmodule
